// File: src/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg: shared constants and helpers for the radix ASCII converter
// Command codes, default sizes and the digit-to-character map.
// ----------------------------------------------------------------------------
package u2a_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [7:0] char_t;

  // Format command codes
  localparam cmd_t CMD_DEC       = 2'd0;
  localparam cmd_t CMD_OCT       = 2'd1;
  localparam cmd_t CMD_HEX_LOWER = 2'd2;
  localparam cmd_t CMD_HEX_UPPER = 2'd3;

  // Default sizes
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Binary bits folded into the BCD register per double-dabble cycle
  localparam int DD_STEP_BITS = 4;

  // ASCII anchors
  localparam char_t ASCII_ZERO  = 8'h30;
  localparam char_t ASCII_LOWER = 8'h61;
  localparam char_t ASCII_UPPER = 8'h41;

  // Map one digit (0..15) to its ASCII character
  function automatic char_t digit_char(logic [3:0] d, logic upper);
    char_t base;
    if (d < 4'd10) begin
      base = ASCII_ZERO + char_t'(d);
    end else if (upper) begin
      base = ASCII_UPPER + char_t'(d - 4'd10);
    end else begin
      base = ASCII_LOWER + char_t'(d - 4'd10);
    end
    return base;
  endfunction

endpackage

// File: src/unsigned_to_ascii_radix_core.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_core: unsigned number to ASCII digits
// Decimal, octal or hex (either case), most significant digit first.
//
//   channel  direction  handshake         payload
//   in       input      in_valid/in_stall  in_value, in_command
//   out      output     out_valid/out_stall out_character, out_last,
//                                           out_char_count
//
// Decimal conversion runs in the double-dabble loop; octal and hex split
// in the accept cycle. Leading zeros are then dropped up to four digits a
// cycle. The emitter loads a digit string from the queue, then puts out
// one character per cycle unless out_stall holds it; the two-entry queue
// lets conversion overlap it.
// Reset is synchronous and clears control only; no clearing pass is needed.
// Output stalls back up through the queue into in_stall.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_radix_core #(
  parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = u2a_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  u2a_pkg::cmd_t          in_command,
  output logic                   out_valid,
  input  logic                   out_stall,
  output u2a_pkg::char_t         out_character,
  output logic                   out_last,
  output logic [3:0]             out_char_count
);

  localparam int MAX_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int DIG_W      = 4 * MAX_DIGITS;
  localparam int CW         = $clog2(MAX_DIGITS + 1);
  localparam int QW         = DIG_W + CW + 1;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [DIG_W-1:0] push_digits;
  logic [CW-1:0]    push_count;
  logic             push_upper;
  logic [QW-1:0]    pop_data;

  u2a_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_command (in_command),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_digits(push_digits),
    .push_count (push_count),
    .push_upper (push_upper)
  );

  u2a_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_digits, push_count, push_upper}),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  u2a_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_digits    (pop_data[QW-1 -: DIG_W]),
    .pop_count     (pop_data[CW:1]),
    .pop_upper     (pop_data[0]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .out_char_count(out_char_count)
  );

endmodule

// File: src/u2a_front.sv
// ----------------------------------------------------------------------------
// u2a_front: accept a number and turn it into a top-aligned digit string
// Octal and hex split the value directly; decimal runs a double-dabble loop.
// Leading zero digits are then dropped a few at a time before the push.
// ----------------------------------------------------------------------------
module u2a_front #(
  parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [VALUE_WIDTH-1:0]                     in_value,
  input  u2a_pkg::cmd_t                              in_command,
  output logic                                       push_valid,
  input  logic                                       push_ready,
  output logic [4*((VALUE_WIDTH+2)/3)-1:0]           push_digits,
  output logic [$clog2((VALUE_WIDTH+2)/3+1)-1:0]     push_count,
  output logic                                       push_upper
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int MAX_DIGITS = OCT_DIGITS;
  localparam int DIG_W      = 4 * MAX_DIGITS;
  localparam int CW         = $clog2(MAX_DIGITS + 1);
  localparam int OCT_W      = 3 * OCT_DIGITS;
  localparam int HEX_W      = 4 * HEX_DIGITS;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int STEP       = u2a_pkg::DD_STEP_BITS;
  localparam int DD_ITERS   = (VALUE_WIDTH + STEP - 1) / STEP;
  localparam int DD_W       = DD_ITERS * STEP;
  localparam int IW         = $clog2(DD_ITERS + 1);
  localparam int NSTEP      = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DEC  = 2'd1;
  localparam logic [1:0] F_NORM = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [DD_W-1:0]  val_r, val_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [IW-1:0]    iter_r, iter_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             upper_r, upper_nxt;

  logic [OCT_W-1:0]        oct_pad;
  logic [4*OCT_DIGITS-1:0] oct_vec;
  logic [HEX_W-1:0]        hex_pad;
  logic [DIG_W-1:0]        oct_dig, hex_dig;
  logic                    accept;
  logic [BCD_W-1:0]        dd_bcd;
  logic [DD_W-1:0]         dd_val;
  logic [2:0]              skip;

  // Split the value into octal and hex digits, top-aligned
  assign oct_pad = OCT_W'(in_value);
  assign hex_pad = HEX_W'(in_value);

  for (genvar j = 0; j < OCT_DIGITS; j++) begin : g_oct
    assign oct_vec[4*j +: 4] = {1'b0, oct_pad[3*j +: 3]};
  end

  assign oct_dig = DIG_W'(oct_vec) << (4 * (MAX_DIGITS - OCT_DIGITS));
  assign hex_dig = DIG_W'(hex_pad) << (4 * (MAX_DIGITS - HEX_DIGITS));

  // Double dabble: fold STEP value bits into the BCD register
  always_comb begin
    dd_bcd = bcd_r;
    dd_val = val_r;
    for (int s = 0; s < STEP; s++) begin
      for (int d = 0; d < DEC_DIGITS; d++) begin
        if (dd_bcd[4*d +: 4] >= 4'd5) begin
          dd_bcd[4*d +: 4] = dd_bcd[4*d +: 4] + 4'd3;
        end
      end
      dd_bcd = {dd_bcd[BCD_W-2:0], dd_val[DD_W-1]};
      dd_val = {dd_val[DD_W-2:0], 1'b0};
    end
  end

  // Count leading zero digits at the top, keeping at least one digit
  always_comb begin
    logic run;
    skip = 3'd0;
    run  = 1'b1;
    for (int i = 0; i < NSTEP; i++) begin
      if (run && (dig_r[DIG_W-4-4*i +: 4] == 4'd0) && (cnt_r > CW'(i + 1))) begin
        skip = skip + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  assign in_stall    = (state_r != F_IDLE);
  assign accept      = in_valid && !in_stall;
  assign push_valid  = (state_r == F_NORM) && (skip == 3'd0);
  assign push_digits = dig_r;
  assign push_count  = cnt_r;
  assign push_upper  = upper_r;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    bcd_nxt   = bcd_r;
    iter_nxt  = iter_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    upper_nxt = upper_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          upper_nxt = (in_command == u2a_pkg::CMD_HEX_UPPER);
          unique case (in_command)
            u2a_pkg::CMD_DEC: begin
              val_nxt   = DD_W'(in_value);
              bcd_nxt   = '0;
              iter_nxt  = IW'(DD_ITERS);
              state_nxt = F_DEC;
            end
            u2a_pkg::CMD_OCT: begin
              dig_nxt   = oct_dig;
              cnt_nxt   = CW'(OCT_DIGITS);
              state_nxt = F_NORM;
            end
            default: begin
              dig_nxt   = hex_dig;
              cnt_nxt   = CW'(HEX_DIGITS);
              state_nxt = F_NORM;
            end
          endcase
        end
      end
      F_DEC: begin
        val_nxt  = dd_val;
        bcd_nxt  = dd_bcd;
        iter_nxt = iter_r - IW'(1);
        if (iter_r == IW'(1)) begin
          dig_nxt   = DIG_W'(dd_bcd) << (4 * (MAX_DIGITS - DEC_DIGITS));
          cnt_nxt   = CW'(DEC_DIGITS);
          state_nxt = F_NORM;
        end
      end
      F_NORM: begin
        if (skip != 3'd0) begin
          dig_nxt = dig_r << {skip, 2'b00};
          cnt_nxt = cnt_r - CW'(skip);
        end else if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    bcd_r   <= bcd_nxt;
    iter_r  <= iter_nxt;
    dig_r   <= dig_nxt;
    cnt_r   <= cnt_nxt;
    upper_r <= upper_nxt;
  end

endmodule

// File: src/u2a_queue.sv
// ----------------------------------------------------------------------------
// u2a_queue: small register queue between the converter and the emitter
// Lets either side stall on its own.
// ----------------------------------------------------------------------------
module u2a_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = u2a_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [FW-1:0]    fill_r;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != FW'(DEPTH));
  assign pop_valid  = (fill_r != FW'(0));
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + FW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - FW'(1);
      end
    end
  end

  // Store the incoming entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/u2a_back.sv
// ----------------------------------------------------------------------------
// u2a_back: emit one ASCII character per word from a queued digit string
// Most significant digit first; the final word carries last and the count.
// ----------------------------------------------------------------------------
module u2a_back #(
  parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       pop_valid,
  output logic                                       pop_ready,
  input  logic [4*((VALUE_WIDTH+2)/3)-1:0]           pop_digits,
  input  logic [$clog2((VALUE_WIDTH+2)/3+1)-1:0]     pop_count,
  input  logic                                       pop_upper,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output u2a_pkg::char_t                             out_character,
  output logic                                       out_last,
  output logic [3:0]                                 out_char_count
);

  localparam int MAX_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int DIG_W      = 4 * MAX_DIGITS;
  localparam int CW         = $clog2(MAX_DIGITS + 1);

  logic                 busy_r;
  logic [DIG_W-1:0]     dig_r;
  logic [CW-1:0]        rem_r, total_r;
  logic                 upper_r;
  logic                 out_valid_r, out_last_r;
  u2a_pkg::char_t       out_character_r;
  logic [3:0]           out_char_count_r;
  logic                 slot_free, is_last, load, emit;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop_ready = !busy_r;
  assign load      = !busy_r && pop_valid;
  assign emit      = busy_r && slot_free;
  assign is_last   = (rem_r == CW'(1));

  assign out_valid      = out_valid_r;
  assign out_character  = out_character_r;
  assign out_last       = out_last_r;
  assign out_char_count = out_char_count_r;

  // Track the busy flag and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (slot_free) begin
        out_valid_r <= busy_r;
      end
    end
  end

  // Load a digit string, then shift out one digit per word
  always_ff @(posedge clk) begin
    if (load) begin
      dig_r   <= pop_digits;
      rem_r   <= pop_count;
      total_r <= pop_count;
      upper_r <= pop_upper;
    end else if (emit) begin
      dig_r <= dig_r << 4;
      rem_r <= rem_r - CW'(1);
    end
    if (emit) begin
      out_character_r  <= u2a_pkg::digit_char(dig_r[DIG_W-1 -: 4], upper_r);
      out_last_r       <= is_last;
      out_char_count_r <= is_last ? 4'(total_r) : 4'd0;
    end
  end

endmodule
